>>> design/bfba_pkg.sv
// Shared constants for the bloom filter bit array core.
package bfba_pkg;

  localparam int HASH_W         = 32;                  // width of one hash word
  localparam int COUNT_W        = 17;                  // width of the bit count register
  localparam int POS_W          = COUNT_W;             // bit position, below the bit count
  localparam int MAX_USED_BITS  = (1 << COUNT_W) - 1;  // largest bit count the register holds
  localparam int MAX_USED_BYTES = (MAX_USED_BITS + 7) / 8;
  localparam int WORD_FIELDS    = 4;                   // hash word ports
  localparam int NUM_HASHES     = 4;
  localparam int NUM_WORDS      = (NUM_HASHES < WORD_FIELDS) ? NUM_HASHES : WORD_FIELDS;
  localparam int WORD_IDX_W     = $clog2(WORD_FIELDS);
  localparam int FILTER_BITS_DEF = 65536;
  localparam int BIT_COUNT_RST_VAL = 65536;            // bit count after reset
  localparam int BITS_PER_CYCLE = 8;                   // remainder bits retired per cycle
  localparam int MOD_STEPS      = HASH_W / BITS_PER_CYCLE;
  localparam int MOD_CNT_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [COUNT_W-1:0] BIT_COUNT_RST = COUNT_W'(BIT_COUNT_RST_VAL);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_CHECK  = 1'b1
  } action_t;

endpackage

>>> design/bfba_mod_unit.sv
// Iterative remainder unit: 32-bit hash word modulo a 17-bit bit count.
module bfba_mod_unit
  import bfba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [HASH_W-1:0]  dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [POS_W-1:0]   remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [HASH_W-1:0]    shift_r;
  logic [COUNT_W-1:0]   div_r;
  logic [COUNT_W-1:0]   rem_r;
  logic [COUNT_W-1:0]   rem_nxt;

  // Restoring division, BITS_PER_CYCLE quotient bits per cycle.
  always_comb begin
    logic [COUNT_W:0] acc;
    acc = {1'b0, rem_r};
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      acc = {acc[COUNT_W-1:0], shift_r[HASH_W-1-k]};
      if (acc >= {1'b0, div_r}) begin
        acc = acc - {1'b0, div_r};
      end
    end
    rem_nxt = acc[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        rem_r   <= '0;
        shift_r <= dividend;
        div_r   <= divisor;
      end else if (busy_r) begin
        rem_r   <= rem_nxt;
        shift_r <= shift_r << BITS_PER_CYCLE;
        cnt_r   <= cnt_r + MOD_CNT_W'(1);
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[POS_W-1:0];

endmodule

>>> design/bfba_store.sv
// Filter byte store: 1R1W synchronous memory with a clearing pass after reset.
module bfba_store
  import bfba_pkg::*;
#(
  parameter int DEPTH  = MAX_USED_BYTES,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  output logic [7:0]        rd_data,
  output logic              clear_busy
);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;

  assign we = clr_busy_r | wr_en;
  assign wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign wd = clr_busy_r ? 8'h00 : wr_data;

  // clear sweep, one byte per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_busy = clr_busy_r;

endmodule

>>> design/bloom_filter_bit_array_core.sv
// Bloom filter bit array core: insert/check of pre-hashed keys against a byte store.
// Per hash word: the remainder unit finds the bit position, the byte read is issued,
//   then the bit is tested and written back on insert; a check stops at its first miss.
// One transaction at a time, set by the serial remainder unit and the single memory
//   port; a zero bit_count skips the store and goes straight to the result.
// Reset: synchronous, rst_n low. bit_count returns to 65536, then a clearing pass zeroes
//   the store one byte per cycle (min(ceil(FILTER_BITS/8), 16384) bytes, 8192 by default).
module bloom_filter_bit_array_core
  import bfba_pkg::*;
#(
  parameter int FILTER_BITS = FILTER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [HASH_W-1:0]  in_hash_word_0,
  input  logic [HASH_W-1:0]  in_hash_word_1,
  input  logic [HASH_W-1:0]  in_hash_word_2,
  input  logic [HASH_W-1:0]  in_hash_word_3,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found
);

  // Positions stay below the saturated bit count, so only the bytes that count covers
  // can be touched.
  localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
  localparam int DEPTH  = (STORE_BYTES < MAX_USED_BYTES) ? STORE_BYTES : MAX_USED_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] BIT_LIMIT =
    (FILTER_BITS < MAX_USED_BITS) ? COUNT_W'(FILTER_BITS) : COUNT_W'(MAX_USED_BITS);

  typedef enum logic [2:0] {
    S_CLEAR,  // store clearing pass after reset
    S_IDLE,   // waiting for a transaction
    S_MOD,    // remainder unit working on the current word
    S_TEST,   // read data back: test bit, write back on insert
    S_DONE    // result ready to move into the output register
  } state_t;

  state_t                  state_r;
  logic [COUNT_W-1:0]      bit_count_r;
  logic [COUNT_W-1:0]      eff_count;
  logic                    in_accept;

  action_t                 action_r;
  logic [HASH_W-1:0]       words_r [WORD_FIELDS];
  logic [WORD_IDX_W-1:0]   widx_r;
  logic [WORD_IDX_W-1:0]   widx_nxt;
  logic                    found_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [2:0]              bitsel_r;
  logic                    out_valid_r;
  logic                    out_found_r;

  // remainder unit hookup
  logic                    mod_start;
  logic [HASH_W-1:0]       mod_dividend;
  logic                    mod_done;
  logic [POS_W-1:0]        mod_rem;

  // store hookup
  logic                    st_rd_en;
  logic [ADDR_W-1:0]       st_addr;
  logic                    st_wr_en;
  logic [7:0]              st_wr_data;
  logic [7:0]              st_rd_data;
  logic                    st_clear_busy;

  logic                    bit_set;
  logic                    last_word;
  logic                    next_word;

  // Counts above the store saturate.
  assign eff_count = (bit_count_r > BIT_LIMIT) ? BIT_LIMIT : bit_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= BIT_COUNT_RST;
    end else if (cfg_wr_en) begin
      bit_count_r <= cfg_wr_data;
    end
  end

  // One transaction in flight; the output register lets the next one start while
  // a finished result still waits downstream.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;

  assign widx_nxt  = widx_r + WORD_IDX_W'(1);
  assign bit_set   = st_rd_data[bitsel_r];
  assign last_word = (widx_r == WORD_IDX_W'(NUM_WORDS - 1));
  // move on unless this was the last word or a check just missed
  assign next_word = (state_r == S_TEST) && !last_word &&
                     !((action_r == ACT_CHECK) && !bit_set);

  assign mod_start    = (in_accept && (eff_count != '0)) || next_word;
  assign mod_dividend = (state_r == S_IDLE) ? in_hash_word_0 : words_r[widx_nxt];

  // Byte index is position >> 3; read issued the cycle the remainder lands.
  assign st_rd_en   = (state_r == S_MOD) && mod_done;
  assign st_addr    = (state_r == S_MOD) ? ADDR_W'(mod_rem[POS_W-1:3]) : addr_r;
  assign st_wr_en   = (state_r == S_TEST) && (action_r == ACT_INSERT);
  assign st_wr_data = st_rd_data | (8'h01 << bitsel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      // drain the output register; S_DONE refills it in the same cycle
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (!st_clear_busy) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            action_r   <= action_t'(in_action);
            words_r[0] <= in_hash_word_0;
            words_r[1] <= in_hash_word_1;
            words_r[2] <= in_hash_word_2;
            words_r[3] <= in_hash_word_3;
            widx_r     <= '0;
            // insert answers 0; zero bit count answers 0 without touching the store
            found_r    <= in_action && (eff_count != '0);
            state_r    <= (eff_count == '0) ? S_DONE : S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            addr_r   <= st_addr;
            bitsel_r <= mod_rem[2:0];
            state_r  <= S_TEST;
          end
        end
        S_TEST: begin
          if ((action_r == ACT_CHECK) && !bit_set) begin
            found_r <= 1'b0;
            state_r <= S_DONE;
          end else if (last_word) begin
            state_r <= S_DONE;
          end else begin
            widx_r  <= widx_nxt;
            state_r <= S_MOD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  bfba_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (eff_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  bfba_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (st_rd_en),
    .rd_addr    (st_addr),
    .wr_en      (st_wr_en),
    .wr_addr    (st_addr),
    .wr_data    (st_wr_data),
    .rd_data    (st_rd_data),
    .clear_busy (st_clear_busy)
  );

endmodule

>>> sim/bloom_filter_bit_array_core_tb.sv
// Self-checking testbench for the bloom filter bit array core.
module bloom_filter_bit_array_core_tb;
  import bfba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limit, well above the slowest correct run: the clearing pass, ~570 keys each with
  // its transaction time plus the longest sender gap and receiver stall, and two LONG_HOLD
  // receiver holds.
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 600;   // receiver hold-off, long enough to back up the input
  localparam int DRAIN_WAIT  = 40;    // settle time at the end, above the latency of one transaction

  typedef logic [WORD_FIELDS-1:0][HASH_W-1:0] hash_set_t;

  // One key transaction as queued for the driver. drain_first holds the key back until
  // every outstanding result has come back.
  typedef struct packed {
    logic      drain_first;
    action_t   action;
    hash_set_t words;
  } key_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic [HASH_W-1:0]  in_hash_word_0 = '0;
  logic [HASH_W-1:0]  in_hash_word_1 = '0;
  logic [HASH_W-1:0]  in_hash_word_2 = '0;
  logic [HASH_W-1:0]  in_hash_word_3 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;

  bloom_filter_bit_array_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_hash_word_0 (in_hash_word_0),
    .in_hash_word_1 (in_hash_word_1),
    .in_hash_word_2 (in_hash_word_2),
    .in_hash_word_3 (in_hash_word_3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow of the filter: one bit per position, plus the bit count register.
  // ---------------------------------------------------------------------------------------
  bit                 filter_shadow [FILTER_BITS_DEF];
  logic [COUNT_W-1:0] bit_count_shadow = BIT_COUNT_RST;

  key_req_t  key_backlog [$];     // keys waiting for the driver
  logic      found_expected [$];  // predicted found flags, oldest first
  hash_set_t recent_keys [$];     // keys inserted under the current bit count

  key_req_t key_on_bus;           // key currently offered on the input channel
  bit       key_taken = 1'b0;     // input transaction accepted at the last rising edge
  int       accepted_cnt = 0;
  int       cycle_count = 0;
  int       fail_count = 0;

  // Insert sets every addressed bit and answers 0; check answers 1 only when every
  // addressed bit is set. Counts above the store saturate; a zero count touches nothing.
  function automatic logic mark_or_probe(key_req_t k);
    logic [COUNT_W-1:0] modulus;
    logic [HASH_W-1:0]  pos;
    logic               all_set;
    modulus = (bit_count_shadow > COUNT_W'(FILTER_BITS_DEF)) ?
              COUNT_W'(FILTER_BITS_DEF) : bit_count_shadow;
    all_set = 1'b1;
    if (modulus == '0) return 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      pos = k.words[i] % HASH_W'(modulus);
      if (k.action == ACT_INSERT) begin
        filter_shadow[pos[POS_W-1:0]] = 1'b1;
      end else if (!filter_shadow[pos[POS_W-1:0]]) begin
        all_set = 1'b0;
      end
    end
    return (k.action == ACT_CHECK) && all_set;
  endfunction

  // Idle length: mostly none or short, a few long; now and then a calm stretch with no
  // idling at all for a few dozen picks.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hash word with extra weight on all-zeros and all-ones
  function automatic logic [HASH_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_key(action_t act, logic [HASH_W-1:0] w0, logic [HASH_W-1:0] w1,
                         logic [HASH_W-1:0] w2, logic [HASH_W-1:0] w3);
    key_req_t k;
    k.drain_first = 1'b0;
    k.action      = act;
    k.words       = {w3, w2, w1, w0};
    key_backlog.push_back(k);
  endtask

  // Random keys: inserts, checks of recently inserted keys (hits), the same with one word
  // swapped (miss at a random word), and fully random checks.
  task automatic queue_random(int n, int drain_at);
    key_req_t k;
    int       pick;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      k.drain_first = (j == drain_at);
      for (int i = 0; i < WORD_FIELDS; i++) k.words[i] = rand_word();
      if (pick < 45) begin
        k.action = ACT_INSERT;
        recent_keys.push_back(k.words);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      end else begin
        k.action = ACT_CHECK;
        if (pick < 80 && recent_keys.size() != 0) begin
          k.words = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
          if (pick >= 68) k.words[$urandom_range(0, WORD_FIELDS - 1)] = rand_word();
        end
      end
      key_backlog.push_back(k);
    end
  endtask

  // Register write, only once the block is idle: nothing queued, nothing offered, nothing
  // outstanding. Every key has a result, so no extra settle time is needed.
  task automatic set_bit_count(logic [COUNT_W-1:0] value);
    while (key_backlog.size() != 0 || in_valid || found_expected.size() != 0)
      @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    bit_count_shadow = value;
    recent_keys.delete();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offers queued keys at the falling edge. Valid stays up until the key is taken;
  // a new key may follow back to back with no dip in valid.
  // ---------------------------------------------------------------------------------------
  int tx_gap_left = 0;
  int tx_calm = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !key_taken)) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid <= 1'b0;
      end else if (key_backlog.size() != 0 &&
                   !(key_backlog[0].drain_first && found_expected.size() != 0)) begin
        key_on_bus = key_backlog.pop_front();
        in_action      <= key_on_bus.action;
        in_hash_word_0 <= key_on_bus.words[0];
        in_hash_word_1 <= key_on_bus.words[1];
        in_hash_word_2 <= key_on_bus.words[2];
        in_hash_word_3 <= key_on_bus.words[3];
        in_valid       <= 1'b1;
        tx_gap_left = pick_gap(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
    key_taken = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Receiver stall. Random stall runs and free runs, plus two long holds once enough
  // keys have gone in, so the block fills and has to stall its own input.
  // ---------------------------------------------------------------------------------------
  int rx_run_left = 0;
  int rx_calm = 0;
  int long_holds_done = 0;
  bit rx_stalled = 1'b0;

  always @(negedge clk) begin
    if (rx_run_left > 0) begin
      rx_run_left--;
    end else if (long_holds_done < 2 &&
                 accepted_cnt >= ((long_holds_done == 0) ? 150 : 420)) begin
      long_holds_done++;
      rx_stalled  = 1'b1;
      rx_run_left = LONG_HOLD;
    end else if (rx_stalled) begin
      rx_stalled  = 1'b0;
      rx_run_left = $urandom_range(0, 12);
    end else begin
      rx_run_left = pick_gap(rx_calm);
      rx_stalled  = (rx_run_left != 0);
      if (rx_stalled) rx_run_left--;
    end
    out_stall <= rx_stalled;
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: at the rising edge, predict each accepted key and check each result against
  // the oldest prediction.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    logic want;
    cycle_count++;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        found_expected.push_back(mark_or_probe(key_on_bus));
        key_taken = 1'b1;
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (found_expected.size() == 0) begin
          $error("found: no transaction pending, actual %0b", out_found);
          fail_count++;
        end else begin
          want = found_expected.pop_front();
          if (out_found !== want) begin
            $error("found: expected %0b, actual %0b", want, out_found);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus, phase by phase over a range of bit counts.
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Full store. The register goes in while the clearing pass is still running.
    set_bit_count(COUNT_W'(FILTER_BITS_DEF));
    add_key(ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h0);             // empty store, first-word miss
    add_key(ACT_INSERT, 32'h0, 32'h0, 32'h0, 32'h0);
    add_key(ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h0);             // hit
    add_key(ACT_INSERT, '1, '1, '1, '1);
    add_key(ACT_CHECK,  '1, '1, '1, '1);                          // top bit, hit
    add_key(ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h1);             // miss on the last word
    add_key(ACT_CHECK,  32'h5, 32'h0, 32'h0, 32'h0);             // miss on the first word
    add_key(ACT_CHECK,  32'h0, '1, 32'h0, 32'h7);                // miss on the last word
    add_key(ACT_INSERT, 32'h1, 32'h2, 32'h3, 32'h0001_0004);     // wraps to position 4
    add_key(ACT_CHECK,  32'h0001_0001, 32'h2, 32'h3, 32'h4);     // aliases, hit
    add_key(ACT_CHECK,  32'h1, 32'h2, 32'h3, 32'h5);             // miss on the last word
    add_key(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    add_key(ACT_CHECK,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    queue_random(110, 60);  // key 60 waits for the pipeline to drain

    // Zero bit count: nothing addressed, every answer is 0, even for keys known present
    set_bit_count('0);
    add_key(ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h0);
    add_key(ACT_INSERT, 32'h9, 32'h9, 32'h9, 32'h9);
    add_key(ACT_CHECK,  32'h9, 32'h9, 32'h9, 32'h9);
    queue_random(30, -1);

    // One bit: every word lands on position 0, which is already set
    set_bit_count(COUNT_W'(1));
    queue_random(30, -1);

    set_bit_count(COUNT_W'(8));
    queue_random(50, -1);

    // Above the store: saturates to the full bit count
    set_bit_count('1);
    queue_random(100, 40);

    set_bit_count(COUNT_W'(37));
    queue_random(60, -1);

    set_bit_count(COUNT_W'(FILTER_BITS_DEF - 1));
    queue_random(60, -1);

    set_bit_count(COUNT_W'(1000));
    queue_random(100, -1);

    while (key_backlog.size() != 0 || in_valid || found_expected.size() != 0)
      @(posedge clk);
    // catch any stray result
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
